// File: hdl/bcf_pkg.sv
// Shared types and constants of the blit copy and fill engine.
`default_nettype none

package bcf_pkg;

	typedef enum logic [1:0] {
		MODE_REG_WRITE = 2'd0,
		MODE_STATUS    = 2'd1,
		MODE_MEM_WRITE = 2'd2,
		MODE_MEM_READ  = 2'd3
	} bus_mode_t;

	localparam logic [15:0] REG_SRC_ADDR   = 16'h0000;
	localparam logic [15:0] REG_DST_ADDR   = 16'h0004;
	localparam logic [15:0] REG_SRC_STRIDE = 16'h0008;
	localparam logic [15:0] REG_DST_STRIDE = 16'h000A;
	localparam logic [15:0] REG_ROW_BYTES  = 16'h000C;
	localparam logic [15:0] REG_ROW_COUNT  = 16'h000E;
	localparam logic [15:0] REG_COMMAND    = 16'h0010;

	localparam logic [15:0] CMD_COPY_ASC  = 16'd1;
	localparam logic [15:0] CMD_COPY_DESC = 16'd3;
	localparam logic [15:0] CMD_FILL      = 16'd5;

	typedef enum logic [1:0] {
		KIND_ASC,
		KIND_DESC,
		KIND_FILL
	} blit_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BLIT,
		ST_RESP
	} bcf_state_t;

endpackage

`default_nettype wire

// File: hdl/bcf_vram.sv
// Video memory: one write port and one registered read port.
`default_nettype none

module bcf_vram #(
	parameter int AW = 16
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);

	logic [7:0] mem [2**AW];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: hdl/blit_copy_fill_engine.sv
// Top level of the blit copy and fill engine.
// Each bus access is taken when start is high and busy is low, and its single
// result appears on read_data with done high for one cycle; the receiver
// cannot stall it. A register write, status read or memory byte write or read
// gives its result in the cycle after the transfer, and the next transfer can
// be taken in the cycle after that. A command write that starts a blit gives
// its result in the cycle in which the last of its bytes (width times rows) is
// written, since the video memory has one read and one write port and each byte
// is read from the source and written to the destination in the following
// cycle, with forwarding when a read hits the byte being written in the same
// cycle.
`default_nettype none

module blit_copy_fill_engine #(
	parameter int MEM_ADDR_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  mode,
	input  wire logic [15:0] offset,
	input  wire logic [31:0] write_data,
	output logic             done,
	output logic      [31:0] read_data
);

	import bcf_pkg::*;

	localparam int AW = MEM_ADDR_BITS;

	bcf_state_t state_q, state_n;

	logic [AW-1:0] src_q, dst_q;
	logic [15:0]   sstride_q, dstride_q, row_bytes_q, row_count_q;
	logic [AW-1:0] sbase_q, dbase_q, sp_q, dp_q;
	logic [15:0]   col_q, row_q;
	blit_kind_t    kind_q;
	logic          rd_q;

	logic          valid_s1, fwd_s1;
	logic [AW-1:0] da_s1;
	logic [7:0]    fwd_data_s1;

	logic          accept, cmd_known, cmd_go, last_col, last_row, fill_wrap;
	logic [31:0]   off_w, sstr_w, dstr_w;
	logic [AW-1:0] off_a, sbase_n, dbase_n;
	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]    mem_wdata, mem_rdata;

	assign accept    = start && !busy;
	assign off_w     = 32'(offset);
	assign off_a     = off_w[AW-1:0];
	assign sstr_w    = 32'(signed'(sstride_q));
	assign dstr_w    = 32'(signed'(dstride_q));
	assign sbase_n   = sbase_q + sstr_w[AW-1:0];
	assign dbase_n   = dbase_q + dstr_w[AW-1:0];
	assign cmd_known = write_data[15:0] inside {CMD_COPY_ASC, CMD_COPY_DESC, CMD_FILL};
	assign cmd_go    = accept && mode == MODE_REG_WRITE && offset == REG_COMMAND && cmd_known
		&& row_bytes_q != 16'd0 && row_count_q != 16'd0;
	assign last_col  = col_q == row_bytes_q - 16'd1;
	assign last_row  = row_q == row_count_q - 16'd1;
	assign fill_wrap = col_q[4:0] == 5'h1F && col_q[15:5] != 11'd0;

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_go) begin
					state_n = ST_BLIT;
				end else if (accept) begin
					state_n = ST_RESP;
				end
			end
			ST_BLIT: begin
				if (last_col && last_row) begin
					state_n = ST_RESP;
				end
			end
			ST_RESP: state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		busy      = state_q != ST_IDLE;
		done      = state_q == ST_RESP;
		read_data = (state_q == ST_RESP && rd_q) ? 32'(mem_rdata) : 32'd0;
	end

	assign mem_raddr = (state_q == ST_BLIT) ? sp_q : off_a;
	assign mem_we    = valid_s1 || (accept && mode == MODE_MEM_WRITE);
	assign mem_waddr = valid_s1 ? da_s1 : off_a;
	assign mem_wdata = valid_s1 ? (fwd_s1 ? fwd_data_s1 : mem_rdata) : write_data[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_s1    <= 1'b0;
			rd_q        <= 1'b0;
			src_q       <= '0;
			dst_q       <= '0;
			sstride_q   <= '0;
			dstride_q   <= '0;
			row_bytes_q <= '0;
			row_count_q <= '0;
		end else begin
			state_q  <= state_n;
			valid_s1 <= state_q == ST_BLIT;
			if (accept) begin
				rd_q <= mode == MODE_MEM_READ;
			end
			if (accept && mode == MODE_REG_WRITE) begin
				case (offset)
					REG_SRC_ADDR:   src_q       <= write_data[AW-1:0];
					REG_DST_ADDR:   dst_q       <= write_data[AW-1:0];
					REG_SRC_STRIDE: sstride_q   <= write_data[15:0];
					REG_DST_STRIDE: dstride_q   <= write_data[15:0];
					REG_ROW_BYTES:  row_bytes_q <= write_data[15:0];
					REG_ROW_COUNT:  row_count_q <= write_data[15:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		da_s1       <= dp_q;
		fwd_s1      <= valid_s1 && da_s1 == sp_q;
		fwd_data_s1 <= mem_wdata;
		if (cmd_go) begin
			sbase_q <= src_q;
			dbase_q <= dst_q;
			sp_q    <= src_q;
			dp_q    <= dst_q;
			col_q   <= 16'd0;
			row_q   <= 16'd0;
			case (write_data[15:0])
				CMD_COPY_DESC: kind_q <= KIND_DESC;
				CMD_FILL:      kind_q <= KIND_FILL;
				default:       kind_q <= KIND_ASC;
			endcase
		end else if (state_q == ST_BLIT) begin
			if (last_col) begin
				col_q   <= 16'd0;
				row_q   <= row_q + 16'd1;
				sbase_q <= sbase_n;
				dbase_q <= dbase_n;
				sp_q    <= sbase_n;
				dp_q    <= dbase_n;
			end else begin
				col_q <= col_q + 16'd1;
				case (kind_q)
					KIND_DESC: begin
						sp_q <= sp_q - AW'(1);
						dp_q <= dp_q - AW'(1);
					end
					KIND_FILL: begin
						sp_q <= fill_wrap ? sp_q - AW'(31) : sp_q + AW'(1);
						dp_q <= dp_q + AW'(1);
					end
					default: begin
						sp_q <= sp_q + AW'(1);
						dp_q <= dp_q + AW'(1);
					end
				endcase
			end
		end
	end

	bcf_vram #(
		.AW(AW)
	) u_vram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule

`default_nettype wire

// File: hdl/bcf_checker.sv
// Port-level checks of the blit copy and fill engine and their binding.
`default_nettype none

module bcf_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [31:0] read_data
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transfer did not raise busy");

	a_done_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe outside a busy transfer");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe not followed by idle");

	a_data_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> read_data == 32'd0)
		else $error("read data driven without a result");

endmodule

bind blit_copy_fill_engine bcf_checker u_bcf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.read_data(read_data)
);

`default_nettype wire

// File: tb/blit_copy_fill_engine_test.sv
// Self-checking testbench for the blit copy and fill engine, with its own memory predictor.
`timescale 1ns / 100ps

module blit_copy_fill_engine_test;
	import bcf_pkg::*;

	localparam int MEM_ADDR_BITS = 16;
	localparam int MEM_SIZE = 1 << MEM_ADDR_BITS;
	localparam int ITEM_TARGET = 1850;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	bus_mode_t mode;
	logic [15:0] offset;
	logic [31:0] write_data;
	logic done;
	logic [31:0] read_data;

	logic [7:0] vmem [0:MEM_SIZE-1];
	bit vmem_valid [0:MEM_SIZE-1];
	logic [15:0] written_list [$];
	logic [15:0] prefill_q [$];
	logic [31:0] src_addr, dst_addr;
	logic [15:0] src_stride, dst_stride, row_bytes, row_count;

	logic [31:0] expected_data_q [$];
	int transfers, mismatches, mem_reads, bytes_moved;
	int asc_blits, desc_blits, fill_blits;
	bit quiet;

	blit_copy_fill_engine #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.offset(offset),
		.write_data(write_data),
		.done(done),
		.read_data(read_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void store_byte(logic [15:0] a, logic [7:0] b);
		vmem[a[MEM_ADDR_BITS-1:0]] = b;
		if (!vmem_valid[a[MEM_ADDR_BITS-1:0]]) begin
			vmem_valid[a[MEM_ADDR_BITS-1:0]] = 1'b1;
			written_list.push_back(a);
		end
	endfunction

	// Walks a blit byte by byte in command order. With apply clear it only collects
	// the source bytes that would be read before anything has written them.
	function automatic void walk_blit(logic [15:0] code, logic [31:0] s, logic [31:0] d,
			logic [15:0] ss, logic [15:0] ds, logic [15:0] w, logic [15:0] h, bit apply);
		logic [31:0] r, i, k, sbase, dbase, sa, da;
		bit planned [int];
		if (!apply)
			prefill_q.delete();
		if (code != CMD_COPY_ASC && code != CMD_COPY_DESC && code != CMD_FILL)
			return;
		for (r = 0; r < h; r++) begin
			sbase = s + r * {{16{ss[15]}}, ss};
			dbase = d + r * {{16{ds[15]}}, ds};
			for (i = 0; i < w; i++) begin
				if (code == CMD_COPY_ASC) begin
					sa = sbase + i;
					da = dbase + i;
				end else if (code == CMD_COPY_DESC) begin
					sa = sbase - i;
					da = dbase - i;
				end else begin
					k = (i < 64) ? i : 32 + ((i - 64) & 31);
					sa = sbase + k;
					da = dbase + i;
				end
				if (apply) begin
					store_byte(da[15:0], vmem[sa[MEM_ADDR_BITS-1:0]]);
				end else begin
					if (!vmem_valid[sa[MEM_ADDR_BITS-1:0]] && !planned.exists(int'(sa[15:0]))) begin
						prefill_q.push_back(sa[15:0]);
						planned[int'(sa[15:0])] = 1'b1;
					end
					planned[int'(da[15:0])] = 1'b1;
				end
			end
		end
		if (apply) begin
			bytes_moved += w * h;
			if (code == CMD_COPY_ASC)
				asc_blits++;
			else if (code == CMD_COPY_DESC)
				desc_blits++;
			else
				fill_blits++;
		end
	endfunction

	function automatic logic [31:0] predict_access(bus_mode_t m, logic [15:0] off,
			logic [31:0] data);
		logic [31:0] rd;
		rd = '0;
		case (m)
			MODE_REG_WRITE: begin
				case (off)
					REG_SRC_ADDR: src_addr = data;
					REG_DST_ADDR: dst_addr = data;
					REG_SRC_STRIDE: src_stride = data[15:0];
					REG_DST_STRIDE: dst_stride = data[15:0];
					REG_ROW_BYTES: row_bytes = data[15:0];
					REG_ROW_COUNT: row_count = data[15:0];
					REG_COMMAND: walk_blit(data[15:0], src_addr, dst_addr, src_stride,
						dst_stride, row_bytes, row_count, 1'b1);
					default: ;
				endcase
			end
			MODE_STATUS: rd = '0;
			MODE_MEM_WRITE: store_byte(off, data[7:0]);
			default: begin
				rd = {24'h0, vmem[off[MEM_ADDR_BITS-1:0]]};
				mem_reads++;
			end
		endcase
		return rd;
	endfunction

	task automatic send_access(bus_mode_t m, logic [15:0] off, logic [31:0] data);
		int gap;
		if (!quiet && $urandom_range(3) == 0) begin
			gap = $urandom_range(1, 3);
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		mode <= m;
		offset <= off;
		write_data <= data;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		expected_data_q.push_back(predict_access(m, off, data));
		transfers++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (expected_data_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_blit(logic [15:0] code, logic [31:0] s, logic [31:0] d,
			logic [15:0] ss, logic [15:0] ds, logic [15:0] w, logic [15:0] h);
		walk_blit(code, s, d, ss, ds, w, h, 1'b0);
		foreach (prefill_q[n])
			send_access(MODE_MEM_WRITE, prefill_q[n], $urandom);
		if (s != src_addr || $urandom_range(1))
			send_access(MODE_REG_WRITE, REG_SRC_ADDR, s);
		if (d != dst_addr || $urandom_range(1))
			send_access(MODE_REG_WRITE, REG_DST_ADDR, d);
		if (ss != src_stride || $urandom_range(1))
			send_access(MODE_REG_WRITE, REG_SRC_STRIDE, {16'($urandom), ss});
		if (ds != dst_stride || $urandom_range(1))
			send_access(MODE_REG_WRITE, REG_DST_STRIDE, {16'($urandom), ds});
		if (w != row_bytes || $urandom_range(1))
			send_access(MODE_REG_WRITE, REG_ROW_BYTES, {16'($urandom), w});
		if (h != row_count || $urandom_range(1))
			send_access(MODE_REG_WRITE, REG_ROW_COUNT, {16'($urandom), h});
		send_access(MODE_REG_WRITE, REG_COMMAND, {16'($urandom), code});
	endtask

	function automatic logic [15:0] pick_stride();
		case ($urandom_range(3))
			0: return 16'h0000;
			1: return 16'($urandom_range(0, 160) - 80);
			2: return 16'($urandom);
			default: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
		endcase
	endfunction

	task automatic random_blit();
		logic [15:0] code, w;
		logic [31:0] s, d;
		case ($urandom_range(2))
			0: code = CMD_COPY_ASC;
			1: code = CMD_COPY_DESC;
			default: code = CMD_FILL;
		endcase
		case ($urandom_range(3))
			0: s = $urandom;
			1: s = 32'hFFFF_FFFF - $urandom_range(0, 100);
			2: s = {16'($urandom), 16'hFFC0 + 16'($urandom_range(0, 63))};
			default: s = $urandom_range(0, 200);
		endcase
		d = $urandom_range(1) ? s + $urandom_range(0, 80) - 40 : $urandom;
		if (code == CMD_FILL && $urandom_range(3) != 0)
			w = 16'($urandom_range(64, 160));
		else
			w = 16'($urandom_range(0, 40));
		run_blit(code, s, d, pick_stride(), pick_stride(), w, 16'($urandom_range(0, 5)));
	endtask

	task automatic test_bus_access();
		send_access(MODE_STATUS, 16'h0000, 32'h0000_0000);
		send_access(MODE_STATUS, 16'hFFFF, 32'hFFFF_FFFF);
		send_access(MODE_MEM_WRITE, 16'h0000, 32'hFFFF_FFFF);
		send_access(MODE_MEM_WRITE, 16'hFFFF, 32'h0000_0000);
		send_access(MODE_MEM_WRITE, 16'h0001, 32'h1234_56A5);
		send_access(MODE_MEM_READ, 16'hFFFF, 32'hFFFF_FFFF);
		send_access(MODE_MEM_READ, 16'h0000, 32'h0000_0000);
		send_access(MODE_REG_WRITE, 16'h0002, 32'hFFFF_FFFF);
		send_access(MODE_REG_WRITE, 16'hFFFF, 32'h0000_0000);
		send_access(MODE_REG_WRITE, REG_COMMAND, 32'h0000_0000);
		send_access(MODE_REG_WRITE, REG_COMMAND, 32'hFFFF_FFFF);
	endtask

	task automatic test_small_blits();
		// Both copies wrap at the top of memory and overlap their own destination.
		run_blit(CMD_COPY_ASC, 32'h0000_FFFF, 32'h0000_0000, 16'h0, 16'h0, 16'd2, 16'd1);
		run_blit(CMD_COPY_DESC, 32'h0000_0000, 32'h0001_0001, 16'h0, 16'h0, 16'd2, 16'd1);
		send_access(MODE_MEM_READ, 16'h0001, $urandom);
	endtask

	task automatic test_large_blits();
		run_blit(CMD_COPY_ASC, 32'h0, 32'h100, 16'h0, 16'h0, 16'hFFFF, 16'h0);
		run_blit(CMD_FILL, 32'h0, 32'h100, 16'h0, 16'h0, 16'h0, 16'hFFFF);
		run_blit(CMD_FILL, 32'h0000_1000, 32'h0000_2000, 16'h0, 16'h0, 16'hFFFF, 16'd1);
		run_blit(CMD_COPY_ASC, 32'hFFFF_FF00, 32'h0000_4000, 16'h0, 16'h1, 16'd1, 16'hFFFF);
		wait_drained();
		run_blit(CMD_COPY_DESC, 32'h0000_8000, 32'h0000_7FFF, 16'h1, 16'h0, 16'hFFFF, 16'd1);
	endtask

	task automatic test_random_traffic();
		int pick, next_pause;
		logic [15:0] off, code;
		next_pause = transfers + 400;
		while (transfers < ITEM_TARGET) begin
			quiet = transfers > ITEM_TARGET * 9 / 10;
			pick = $urandom_range(19);
			if (pick < 6) begin
				random_blit();
			end else if (pick < 11) begin
				send_access(MODE_MEM_WRITE, 16'($urandom), $urandom);
			end else if (pick < 16) begin
				send_access(MODE_MEM_READ,
					written_list[$urandom_range(written_list.size() - 1)], $urandom);
			end else if (pick == 16) begin
				send_access(MODE_STATUS, 16'($urandom), $urandom);
			end else if (pick == 17) begin
				do
					off = $urandom_range(1) ? 16'($urandom_range(0, 31)) : 16'($urandom);
				while (off == REG_SRC_ADDR || off == REG_DST_ADDR || off == REG_SRC_STRIDE
					|| off == REG_DST_STRIDE || off == REG_ROW_BYTES || off == REG_ROW_COUNT
					|| off == REG_COMMAND);
				send_access(MODE_REG_WRITE, off, $urandom);
			end else if (pick == 18) begin
				do
					code = $urandom_range(1) ? 16'($urandom_range(0, 7)) : 16'($urandom);
				while (code == CMD_COPY_ASC || code == CMD_COPY_DESC || code == CMD_FILL);
				send_access(MODE_REG_WRITE, REG_COMMAND, {16'($urandom), code});
			end else begin
				case ($urandom_range(5))
					0: off = REG_SRC_ADDR;
					1: off = REG_DST_ADDR;
					2: off = REG_SRC_STRIDE;
					3: off = REG_DST_STRIDE;
					4: off = REG_ROW_BYTES;
					default: off = REG_ROW_COUNT;
				endcase
				send_access(MODE_REG_WRITE, off, $urandom);
			end
			if (transfers >= next_pause) begin
				wait_drained();
				next_pause = transfers + 400;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_data_q.size() == 0) begin
				$error("read_data: no transfer pending, actual %h", read_data);
				mismatches++;
			end else begin
				if (read_data !== expected_data_q[0]) begin
					$error("read_data: expected %h, actual %h", expected_data_q[0], read_data);
					mismatches++;
				end
				void'(expected_data_q.pop_front());
			end
		end
	end

	initial begin
		#40_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		mode = MODE_STATUS;
		offset = '0;
		write_data = '0;
		src_addr = '0;
		dst_addr = '0;
		src_stride = '0;
		dst_stride = '0;
		row_bytes = '0;
		row_count = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_bus_access();
		test_small_blits();
		test_large_blits();
		test_random_traffic();
		wait_drained();
		repeat (20) @(posedge clk);
		$display("Ran %0d bus transfers with %0d memory reads checked.", transfers, mem_reads);
		$display("Blits: %0d ascending copies, %0d descending copies, %0d fills, %0d bytes moved.",
			asc_blits, desc_blits, fill_blits, bytes_moved);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
